/* hdl/wfir_pkg.sv */
// wfir_pkg: shared types, widths and tap coefficients of the windowed-sinc fir
// no dependencies; used by the channel interfaces, the cells and the top level
`default_nettype none

package wfir_pkg;

   localparam int TAPS       = 17;
   localparam int HIST_DEPTH = TAPS - 1;
   localparam int SAMPLE_W   = 8;
   localparam int COEF_W     = 9;
   localparam int ACC_W      = 18;  // covers -21420 .. 86700

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [SAMPLE_W-1:0]      sample_type;

   // hanning-windowed sinc, scaled by 2^8, sums to 256
   localparam coef_type COEF [TAPS] = '{
      9'sd0, -9'sd1, 9'sd2, 9'sd0, -9'sd7, 9'sd19, -9'sd34, 9'sd46, 9'sd206,
      9'sd46, -9'sd34, 9'sd19, -9'sd7, 9'sd0, 9'sd2, -9'sd1, 9'sd0
   };

   typedef struct packed {
      logic advance;  // data word accepted, shift partial sums
      logic clear;    // clear word accepted, zero partial sums
   } cell_ctrl_type;

   function automatic acc_type tap_product(input sample_type x, input coef_type c);
      logic signed [SAMPLE_W:0] xs;
      acc_type p;
      xs = {1'b0, x};
      p = acc_type'(xs) * acc_type'(c);
      return p;
   endfunction

endpackage

`default_nettype wire

/* hdl/wfir_if.sv */
// wfir_req_if, wfir_rsp_if: valid/ready channels of the fir
// depends on wfir_pkg for the field widths
`default_nettype none

interface wfir_req_if;
   logic                       valid;
   logic                       ready;
   logic [wfir_pkg::SAMPLE_W-1:0] sample;
   logic                       clear_history;

   modport source(output valid, output sample, output clear_history, input ready);
   modport sink(input valid, input sample, input clear_history, output ready);
endinterface

interface wfir_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [wfir_pkg::SAMPLE_W-1:0] filtered;

   modport source(output valid, output filtered, input ready);
   modport sink(input valid, input filtered, output ready);
endinterface

`default_nettype wire

/* hdl/windowed_sinc_fir_lowpass.sv */
// windowed_sinc_fir_lowpass: 17-tap transposed fir, a row of 16 partial-sum cells
// the filtered word is valid in the cycle after its sample word is accepted
// throughput: one word per cycle unless rsp stalls, set by the single add in each chain cell
// a clear word zeroes every partial sum and gives no result
// synchronous active-high reset zeroes the partial sums and empties the output register
// depends on wfir_pkg, wfir_if, wfir_cell and wfir_out
`default_nettype none

module windowed_sinc_fir_lowpass (
   input  wire logic clock,
   input  wire logic reset,
   wfir_req_if.sink   req_if,
   wfir_rsp_if.source rsp_if
);
   import wfir_pkg::*;

   // handshake: a word enters when the output register is empty or being drained
   logic          accept;
   cell_ctrl_type ctrl;

   // psum[k-1] is the partial sum held by the cell of tap k; psum[HIST_DEPTH] feeds the tail
   acc_type psum [HIST_DEPTH+1];

   assign req_if.ready = !rsp_if.valid || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign ctrl.advance = accept && !req_if.clear_history;
   assign ctrl.clear   = accept && req_if.clear_history;

   // nothing beyond the last tap
   assign psum[HIST_DEPTH] = '0;

   // each cell adds its tap product to the sum handed down from its neighbor
   for (genvar k = 1; k <= HIST_DEPTH; k++) begin : g_cell
      wfir_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sample  (req_if.sample),
         .coef    (COEF[k]),
         .sum_in  (psum[k]),
         .sum_out (psum[k-1])
      );
   end

   // tap 0 joins the head of the chain, then clamp and register
   wfir_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (ctrl.advance),
      .sample   (req_if.sample),
      .head_sum (psum[0]),
      .rsp      (rsp_if)
   );

`ifndef SYNTHESIS
   a_data_gives_word: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |=> rsp_if.valid)
      else $error("accepted sample word produced no result");

   a_clear_no_word: assert property (@(posedge clock) disable iff (reset)
      (ctrl.clear && rsp_if.ready) |=> !rsp_if.valid)
      else $error("clear word produced a result");

   a_clear_zeroes_chain: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (psum[0] == '0 && psum[HIST_DEPTH-1] == '0))
      else $error("partial sums not cleared");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("output register not empty after reset");
`endif

endmodule

`default_nettype wire

/* hdl/wfir_cell.sv */
// wfir_cell: one tap of the transposed fir, holds one partial sum
// depends on wfir_pkg
`default_nettype none

module wfir_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wfir_pkg::cell_ctrl_type ctrl,
   input  wire wfir_pkg::sample_type   sample,
   input  wire wfir_pkg::coef_type     coef,
   input  wire wfir_pkg::acc_type      sum_in,
   output wfir_pkg::acc_type           sum_out
);
   import wfir_pkg::*;

   acc_type sum_ff;
   acc_type sum_in_next;

   always_comb begin
      sum_in_next = sum_ff;
      if (ctrl.clear) begin
         sum_in_next = '0;
      end else if (ctrl.advance) begin
         sum_in_next = tap_product(sample, coef) + sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in_next;
      end
   end

   assign sum_out = sum_ff;

endmodule

`default_nettype wire

/* hdl/wfir_out.sv */
// wfir_out: final tap add, clamp to 0..255 and output word register
// depends on wfir_pkg and wfir_rsp_if
`default_nettype none

module wfir_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire wfir_pkg::sample_type sample,
   input  wire wfir_pkg::acc_type    head_sum,
   wfir_rsp_if.source                rsp
);
   import wfir_pkg::*;

   acc_type    acc;
   sample_type clamped;
   logic       valid_ff;
   logic       valid_in;
   sample_type filtered_ff;

   always_comb begin
      acc = tap_product(sample, COEF[0]) + head_sum;
      if (acc[ACC_W-1]) begin
         clamped = '0;
      end else if (acc[ACC_W-2:2*SAMPLE_W] != '0) begin
         clamped = '1;
      end else begin
         clamped = acc[2*SAMPLE_W-1:SAMPLE_W];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         filtered_ff <= clamped;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.filtered = filtered_ff;

endmodule

`default_nettype wire
